FILE: rtl/earth_frame_rotation_assert.svh
// ---------------------------------------------------------------------------
// Earth frame rotation assertion macros
// Concurrent assertion wrappers that vanish in synthesis.
// ---------------------------------------------------------------------------
`ifndef EARTH_FRAME_ROTATION_ASSERT_SVH
`define EARTH_FRAME_ROTATION_ASSERT_SVH
`ifndef SYNTHESIS
`define EFR_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error("earth_frame_rotation assertion failed");
`define EFR_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("earth_frame_rotation assertion failed");
`else
`define EFR_ASSERT(lbl, prop)
`define EFR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/efr_pkg.sv
// ---------------------------------------------------------------------------
// Earth frame rotation package
// Widths, constants, tables and beat types shared by the pipeline.
// ---------------------------------------------------------------------------
package efr_pkg;
  localparam int CORDIC_STAGES = 24;
  localparam int COORD_WIDTH   = 32;
  localparam int GUARD_BITS    = 61 - COORD_WIDTH;
  localparam int DW            = COORD_WIDTH + GUARD_BITS + 3;
  localparam int ZW            = 34;
  localparam int TW            = 48;
  localparam int RATE_W        = 56;
  localparam int ANG_W         = 32;
  localparam int CFG_W         = 56;
  localparam int LATENCY       = CORDIC_STAGES + 6;
  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam int RND_POS       = 31 + GUARD_BITS;
  localparam int SHIFT         = 32 + GUARD_BITS;
  localparam int TOT_W         = DW + 33;
  localparam int RW            = TOT_W - SHIFT;

  localparam logic [47:0] EPOCH_RST = 48'd62044766208000;
  localparam logic [55:0] RATE_RST  = 56'd836284000000;
  localparam logic [31:0] PHASE_RST = 32'd3346024337;

  typedef enum logic [1:0] {
    REG_EPOCH = 2'd0,
    REG_RATE  = 2'd1,
    REG_PHASE = 2'd2
  } reg_idx_e;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic                          op;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } item_t;

  typedef struct packed {
    logic                          valid;
    logic [ANG_W-1:0]              ang;
    item_t                         item;
  } ang_beat_t;

  typedef struct packed {
    logic                          valid;
    logic signed [DW-1:0]          x;
    logic signed [DW-1:0]          y;
    logic signed [COORD_WIDTH-1:0] z;
  } rot_beat_t;
endpackage

FILE: rtl/earth_frame_rotation.sv
// ---------------------------------------------------------------------------
// Earth frame rotation
// Rotates a vector about z by the Earth rotation angle at a given time.
// ---------------------------------------------------------------------------
// The block takes one vector beat in every clock cycle and busy stays low.
// Each result reaches done_o through the angle stages (time, products,
// angle), the pre-rotation register, the fully pipelined CORDIC with one
// register per iteration and the two output stages for gain and rounding.
// Results cannot be held off, so the receiver must take every done_o beat.
// Configuration writes must only be issued while no beat is in flight.
module earth_frame_rotation (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  output logic                                   done_o,
  input  logic                                   operation_i,
  input  logic [efr_pkg::TW-1:0]                 time_stamp_i,
  input  logic signed [efr_pkg::COORD_WIDTH-1:0] in_x_i,
  input  logic signed [efr_pkg::COORD_WIDTH-1:0] in_y_i,
  input  logic signed [efr_pkg::COORD_WIDTH-1:0] in_z_i,
  output logic signed [efr_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [efr_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic signed [efr_pkg::COORD_WIDTH-1:0] out_z_o,
  output logic                                   saturated_o,
  input  logic                                   cfg_we_i,
  input  logic [1:0]                             cfg_idx_i,
  input  logic [efr_pkg::CFG_W-1:0]              cfg_data_i
);
  import efr_pkg::*;
`include "earth_frame_rotation_assert.svh"

  logic [TW-1:0]     epoch_q;
  logic [RATE_W-1:0] rate_q;
  logic [ANG_W-1:0]  phase_q;
  item_t             item;
  ang_beat_t         ang_beat;
  rot_beat_t         rot_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EPOCH_RST;
      rate_q  <= RATE_RST;
      phase_q <= PHASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EPOCH: epoch_q <= cfg_data_i[TW-1:0];
        REG_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
        REG_PHASE: phase_q <= cfg_data_i[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  assign item = '{op: operation_i, x: in_x_i, y: in_y_i, z: in_z_i};

  efr_angle u_angle (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start && !busy),
    .item_i       (item),
    .time_stamp_i (time_stamp_i),
    .epoch_i      (epoch_q),
    .rate_i       (rate_q),
    .phase_i      (phase_q),
    .beat_o       (ang_beat)
  );

  efr_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (ang_beat),
    .beat_o (rot_beat)
  );

  efr_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (rot_beat),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .saturated_o (saturated_o)
  );

  `EFR_ASSERT(a_latency, (start && !busy) |-> ##LATENCY done_o)
  `EFR_ASSERT(a_z_pass, (start && !busy) |-> ##LATENCY (out_z_o == $past(in_z_i, LATENCY)))
  `EFR_ASSERT_ALWAYS(a_sat_strobe, saturated_o |-> done_o)
endmodule

FILE: rtl/efr_angle.sv
// ---------------------------------------------------------------------------
// Earth rotation angle
// Elapsed time, split rate product, phase add and direction select.
// ---------------------------------------------------------------------------
module efr_angle (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  efr_pkg::item_t             item_i,
  input  logic [efr_pkg::TW-1:0]     time_stamp_i,
  input  logic [efr_pkg::TW-1:0]     epoch_i,
  input  logic [efr_pkg::RATE_W-1:0] rate_i,
  input  logic [efr_pkg::ANG_W-1:0]  phase_i,
  output efr_pkg::ang_beat_t         beat_o
);
  import efr_pkg::*;

  logic              v1_q, v2_q, v3_q;
  item_t             it1_q, it2_q, it3_q;
  logic signed [TW:0] d_q;
  logic [52:0]        ll_q, hl_q;
  logic signed [52:0] lh_q, hh_q;
  logic [71:0]        sum;
  logic [ANG_W-1:0]   ang_d, ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign sum = 72'(ll_q) + (72'(hl_q) << 28) + (72'(lh_q) << 25) + (72'(hh_q) << 53);

  always_comb begin
    ang_d = sum[71:40] + phase_i;
    if (it2_q.op) begin
      ang_d = ANG_W'(0) - ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it1_q <= item_i;
    d_q   <= $signed({1'b0, time_stamp_i}) - $signed({1'b0, epoch_i});
    it2_q <= it1_q;
    ll_q  <= rate_i[27:0] * d_q[24:0];
    hl_q  <= rate_i[55:28] * d_q[24:0];
    lh_q  <= $signed({1'b0, rate_i[27:0]}) * $signed(d_q[TW:25]);
    hh_q  <= $signed({1'b0, rate_i[55:28]}) * $signed(d_q[TW:25]);
    it3_q <= it2_q;
    ang_q <= ang_d;
  end

  assign beat_o.valid = v3_q;
  assign beat_o.ang   = ang_q;
  assign beat_o.item  = it3_q;
endmodule

FILE: rtl/efr_cordic.sv
// ---------------------------------------------------------------------------
// Earth frame rotation CORDIC
// Quarter-turn pre-rotation and one registered CORDIC stage per iteration.
// ---------------------------------------------------------------------------
module efr_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  efr_pkg::ang_beat_t beat_i,
  output efr_pkg::rot_beat_t beat_o
);
  import efr_pkg::*;

  localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  logic                          v_q  [0:N];
  logic signed [DW-1:0]          x_q  [0:N];
  logic signed [DW-1:0]          y_q  [0:N];
  logic signed [ZW-1:0]          a_q  [0:N];
  logic signed [COORD_WIDTH-1:0] pz_q [0:N];

  logic [1:0]           quad;
  logic [ANG_W-1:0]     res;
  logic signed [DW-1:0] xi, yi, xr, yr;

  always_comb begin
    quad = 2'(({1'b0, beat_i.ang} + 33'h020000000) >> 30);
    res  = beat_i.ang - {quad, 30'd0};
    xi   = DW'(beat_i.item.x);
    yi   = DW'(beat_i.item.y);
    case (quad)
      2'd0: begin
        xr = xi;
        yr = yi;
      end
      2'd1: begin
        xr = -yi;
        yr = xi;
      end
      2'd2: begin
        xr = -xi;
        yr = -yi;
      end
      default: begin
        xr = yi;
        yr = -xi;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= xr <<< GUARD_BITS;
    y_q[0]  <= yr <<< GUARD_BITS;
    a_q[0]  <= ZW'($signed(res));
    pz_q[0] <= beat_i.item.z;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [DW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = ZW'(ATAN_TURNS[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!a_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        a_q[i+1] <= a_q[i] - at;
      end else begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        a_q[i+1] <= a_q[i] + at;
      end
      pz_q[i+1] <= pz_q[i];
    end
  end

  assign beat_o.valid = v_q[N];
  assign beat_o.x     = x_q[N];
  assign beat_o.y     = y_q[N];
  assign beat_o.z     = pz_q[N];
endmodule

FILE: rtl/efr_finish.sv
// ---------------------------------------------------------------------------
// Earth frame rotation output scaling
// Gain multiply in two partial products, rounding and saturation.
// ---------------------------------------------------------------------------
module efr_finish (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  efr_pkg::rot_beat_t                  beat_i,
  output logic                                done_o,
  output logic signed [efr_pkg::COORD_WIDTH-1:0] out_x_o,
  output logic signed [efr_pkg::COORD_WIDTH-1:0] out_y_o,
  output logic signed [efr_pkg::COORD_WIDTH-1:0] out_z_o,
  output logic                                saturated_o
);
  import efr_pkg::*;

  localparam logic [RW-1:0] LIM = RW'(1) << (COORD_WIDTH - 1);

  logic                          v_q, done_q;
  logic                          nx_q, ny_q;
  logic [DW-1:0]                 mx, my;
  logic [DW-1:0]                 hx_q, lx_q, hy_q, ly_q;
  logic signed [COORD_WIDTH-1:0] z1_q;
  logic [RW-1:0]                 rx, ry;
  logic [COORD_WIDTH-1:0]        ox, oy;
  logic                          sx, sy;
  logic signed [COORD_WIDTH-1:0] ox_q, oy_q, oz_q;
  logic                          sat_q;

  function automatic logic [RW-1:0] round_mag(logic [DW-1:0] h, logic [DW-1:0] l);
    logic [TOT_W-1:0] t;
    t = (TOT_W'(h) << 32) + TOT_W'(l) + (TOT_W'(1) << RND_POS);
    return t[TOT_W-1:SHIFT];
  endfunction

  assign mx = beat_i.x[DW-1] ? DW'(-beat_i.x) : DW'(beat_i.x);
  assign my = beat_i.y[DW-1] ? DW'(-beat_i.y) : DW'(beat_i.y);

  always_comb begin
    rx = round_mag(hx_q, lx_q);
    ry = round_mag(hy_q, ly_q);
    sx = 1'b0;
    sy = 1'b0;
    if (nx_q) begin
      if (rx > LIM) begin
        sx = 1'b1;
        rx = LIM;
      end
      ox = COORD_WIDTH'(-rx);
    end else begin
      if (rx > LIM - RW'(1)) begin
        sx = 1'b1;
        rx = LIM - RW'(1);
      end
      ox = COORD_WIDTH'(rx);
    end
    if (ny_q) begin
      if (ry > LIM) begin
        sy = 1'b1;
        ry = LIM;
      end
      oy = COORD_WIDTH'(-ry);
    end else begin
      if (ry > LIM - RW'(1)) begin
        sy = 1'b1;
        ry = LIM - RW'(1);
      end
      oy = COORD_WIDTH'(ry);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v_q    <= beat_i.valid;
      done_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q  <= beat_i.x[DW-1];
    ny_q  <= beat_i.y[DW-1];
    hx_q  <= mx[DW-1:32] * GAIN_Q32;
    lx_q  <= mx[31:0] * GAIN_Q32;
    hy_q  <= my[DW-1:32] * GAIN_Q32;
    ly_q  <= my[31:0] * GAIN_Q32;
    z1_q  <= beat_i.z;
    ox_q  <= ox;
    oy_q  <= oy;
    oz_q  <= z1_q;
    sat_q <= sx | sy;
  end

  assign done_o      = done_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign saturated_o = sat_q & done_q;
endmodule

FILE: test/tb.sv
// ---------------------------------------------------------------------------
// Earth frame rotation testbench
// Checks the rotation pipeline against its own predictor. It writes several
// register settings, extremes among them, and drives directed and random
// vector beats with varied sender gaps. Every result is compared field by
// field, in order.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efr_pkg::*;

  typedef struct {
    logic                          op;
    logic [TW-1:0]                 ts;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } vec_beat_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          sat;
  } rotated_t;

  class rotation_scoreboard;
    logic [TW-1:0]     epoch;
    logic [RATE_W-1:0] rate;
    logic [ANG_W-1:0]  phase;
    rotated_t          pending[$];
    int                errors;
    int                checked;

    function new();
      epoch = EPOCH_RST;
      rate  = RATE_RST;
      phase = PHASE_RST;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] scale_round(logic signed [63:0] v,
                                                           ref logic sat);
      logic [63:0]  mag;
      logic [127:0] r;
      mag = v[63] ? -v : v;
      r = (128'(mag) * 128'(GAIN_Q32) + (128'd1 << 60)) >> 61;
      if (v[63]) begin
        if (r > 128'h8000_0000) begin
          sat = 1'b1;
          r = 128'h8000_0000;
        end
        return COORD_WIDTH'(-r);
      end
      if (r > 128'h7fff_ffff) begin
        sat = 1'b1;
        r = 128'h7fff_ffff;
      end
      return COORD_WIDTH'(r);
    endfunction

    function automatic rotated_t rotate(vec_beat_t b);
      logic signed [TW:0]   dt;
      logic signed [104:0]  prod;
      logic [31:0]          ang;
      logic [31:0]          res;
      logic [1:0]           q;
      logic signed [63:0]   x, y, t, zr, xs, ys;
      rotated_t             o;
      dt   = $signed({1'b0, b.ts}) - $signed({1'b0, epoch});
      prod = $signed({49'd0, rate}) * $signed({{56{dt[TW]}}, dt});
      ang  = prod[71:40] + phase;
      if (b.op) ang = -ang;
      q    = 2'((ang + 32'h2000_0000) >> 30);
      res  = ang - {q, 30'd0};
      zr   = 64'(signed'(res));
      x = 64'(b.x);
      y = 64'(b.y);
      case (q)
        2'd1: begin
          t = x; x = -y; y = t;
        end
        2'd2: begin
          x = -x; y = -y;
        end
        2'd3: begin
          t = x; x = y; y = -t;
        end
        default: ;
      endcase
      x = x <<< GUARD_BITS;
      y = y <<< GUARD_BITS;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (zr >= 0) begin
          x -= ys; y += xs; zr -= 64'(ATAN_TURNS[i]);
        end else begin
          x += ys; y -= xs; zr += 64'(ATAN_TURNS[i]);
        end
      end
      o.sat = 1'b0;
      o.x = scale_round(x, o.sat);
      o.y = scale_round(y, o.sat);
      o.z = b.z;
      return o;
    endfunction

    function void note_beat(vec_beat_t b);
      pending.push_back(rotate(b));
    endfunction

    function void check_result(rotated_t got);
      rotated_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $error("result with no beat outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.x !== exp_r.x) begin
        $error("out_x: expected %0d, got %0d", exp_r.x, got.x);
        errors++;
      end
      if (got.y !== exp_r.y) begin
        $error("out_y: expected %0d, got %0d", exp_r.y, got.y);
        errors++;
      end
      if (got.z !== exp_r.z) begin
        $error("out_z: expected %0d, got %0d", exp_r.z, got.z);
        errors++;
      end
      if (got.sat !== exp_r.sat) begin
        $error("saturated: expected %0b, got %0b", exp_r.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          done_o;
  logic                          operation_i = 1'b0;
  logic [TW-1:0]                 time_stamp_i = '0;
  logic signed [COORD_WIDTH-1:0] in_x_i = '0;
  logic signed [COORD_WIDTH-1:0] in_y_i = '0;
  logic signed [COORD_WIDTH-1:0] in_z_i = '0;
  logic signed [COORD_WIDTH-1:0] out_x_o;
  logic signed [COORD_WIDTH-1:0] out_y_o;
  logic signed [COORD_WIDTH-1:0] out_z_o;
  logic                          saturated_o;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_idx_i = '0;
  logic [CFG_W-1:0]              cfg_data_i = '0;

  rotation_scoreboard sb = new();
  int idle_pct;
  int n_beats;
  int n_cfg;

  earth_frame_rotation u_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{out_x_o, out_y_o, out_z_o, saturated_o});
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_EPOCH: sb.epoch = val[TW-1:0];
      REG_RATE:  sb.rate  = val[RATE_W-1:0];
      default:   sb.phase = val[ANG_W-1:0];
    endcase
    n_cfg++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic configure(logic [TW-1:0] ep, logic [RATE_W-1:0] rt, logic [ANG_W-1:0] ph);
    drain();
    write_reg(REG_EPOCH, CFG_W'(ep));
    write_reg(REG_RATE, CFG_W'(rt));
    write_reg(REG_PHASE, CFG_W'(ph));
  endtask

  task automatic send(vec_beat_t b);
    @(negedge clk_i);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start        <= 1'b1;
    operation_i  <= b.op;
    time_stamp_i <= b.ts;
    in_x_i       <= b.x;
    in_y_i       <= b.y;
    in_z_i       <= b.z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_beat(b);
    n_beats++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return 32'(signed'($urandom_range(2000)) - 1000);
      2: return 32'($urandom) >>> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_beat_t rand_beat();
    vec_beat_t b;
    b.op = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: b.ts = TW'({$urandom, $urandom});
      1: b.ts = sb.epoch + TW'(signed'($urandom) >>> $urandom_range(20));
      default: b.ts = EPOCH_RST + TW'({$urandom_range(32'h3fff), $urandom});
    endcase
    b.x = rand_coord();
    b.y = rand_coord();
    b.z = $urandom;
    return b;
  endfunction

  task automatic random_run(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      send(rand_beat());
    end
  endtask

  initial begin
    vec_beat_t b;
    logic signed [31:0] mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 0;
    send('{1'b0, 48'd0, mx, mx, mx});
    send('{1'b1, 48'hffff_ffff_ffff, mn, mn, mn});
    send('{1'b0, EPOCH_RST, mx, mn, 32'sd0});
    send('{1'b1, EPOCH_RST, mn, mx, -32'sd1});
    send('{1'b0, EPOCH_RST - 48'd1, 32'sd1, 32'sd0, 32'sd5});
    send('{1'b0, 48'd0, 32'sd0, 32'sd0, 32'sd0});
    send('{1'b1, EPOCH_RST + 48'h5460_0000, mx, 32'sd0, 32'sd7});
    configure(48'd0, 56'd0, 32'd0);
    for (int k = 0; k < 8; k++) begin
      drain();
      write_reg(REG_PHASE, CFG_W'(32'h1000_0000 * k));
      send('{k[0], 48'd0, mx, mn, 32'sd3});
      send('{~k[0], 48'hffff_ffff_ffff, mn, mn, 32'sd3});
    end

    configure(48'hffff_ffff_ffff, 56'hff_ffff_ffff_ffff, 32'hffff_ffff);
    random_run(150, 0);
    configure(48'd0, 56'hff_ffff_ffff_ffff, 32'd0);
    random_run(150, 55);
    configure(EPOCH_RST, RATE_RST, PHASE_RST);
    random_run(350, 0);
    random_run(300, 55);
    configure(TW'({$urandom, $urandom}), RATE_W'({$urandom, $urandom}), $urandom);
    random_run(150, 8);
    configure(48'hffff_ffff_ffff, 56'd1, 32'h8000_0000);
    random_run(150, 8);

    drain();
    $display("Drove %0d vector beats across %0d register writes; %0d results checked.",
             n_beats, n_cfg, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/efr_pkg.sv
rtl/efr_angle.sv
rtl/efr_cordic.sv
rtl/efr_finish.sv
rtl/earth_frame_rotation.sv
test/tb.sv
